// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files; only the scheduler core uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a property holds at every clock edge, with reset checked as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== sv/eds_pkg.sv =====
// Package with constants, types and codes of the elevator destination scheduler.
`default_nettype none
package eds_pkg;
  localparam int FloorCount  = 16;
  localparam int CarCapacity = 8;
  localparam int QueueDepth  = 8;
  localparam int FloorW = $clog2(FloorCount);
  localparam int RiderW = $clog2(CarCapacity);
  localparam int SlotW  = $clog2(QueueDepth);
  localparam int CntW   = $clog2(QueueDepth + 1);
  localparam int LoadW  = $clog2(CarCapacity + 1);
  localparam int StoreW = FloorW + SlotW;

  typedef enum logic [1:0] {
    FuncTick    = 2'd0,
    FuncEnqueue = 2'd1,
    FuncBoard   = 2'd2,
    FuncAlight  = 2'd3
  } func_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;       // capture the input beat
    logic clr_prio;   // clear priority accumulators
    logic rider_acc;  // add rider k to its destination floor
    logic floor_acc;  // add floor f queue time
    logic cmp_init;   // start the best search
    logic cmp_step;   // compare floor f against best
    logic set_target; // write best to target
    logic move;       // step the car
    logic enqueue;    // perform enqueue
    logic board_rd;   // issue read of the head slot
    logic board_wr;   // board one person into rider k
    logic alight;     // alight rider k if bound for the current floor
    logic [RiderW-1:0] k;
    logic [FloorW-1:0] f;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  at_target;
    logic  rider_free; // rider k is empty
    logic  queue_busy; // current floor has waiting people
  } sts_t;
endpackage
`default_nettype wire

// ===== sv/eds_datapath.sv =====
// Datapath: car, rider and queue state, priority sums and best search.
`default_nettype none
module eds_datapath import eds_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              prefer_top_i,
  input  wire logic [1:0]        func_i,
  input  wire logic [15:0]       now_i,
  input  wire logic [3:0]        call_floor_i,
  input  wire logic [3:0]        trip_floor_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  output logic [3:0]             car_floor_o,
  output logic [3:0]             target_floor_o,
  output logic [3:0]             riders_o,
  output logic [3:0]             boarded_o,
  output logic [3:0]             alighted_o,
  output logic                   status_o
);
  logic [1:0]  func_q;
  logic [15:0] now_q;
  logic [3:0]  call_q, trip_q;
  logic [FloorW-1:0] pos_q, tgt_q;
  logic [CarCapacity-1:0] rv_q;
  logic [FloorW-1:0] rdest_q [CarCapacity];
  logic [15:0] rtime_q [CarCapacity];
  logic [SlotW-1:0] head_q [FloorCount];
  logic [CntW-1:0]  cnt_q [FloorCount];
  logic [15:0] stamp_q [FloorCount];
  logic [31:0] prio_q [FloorCount];
  logic [31:0] best_p_q;
  logic [FloorW-1:0] best_q;
  logic [3:0] boarded_q, alighted_q;
  logic status_q;
  logic [FloorW-1:0] mem_q [2**StoreW];
  logic [FloorW-1:0] rd_q;
  logic [LoadW-1:0] load;
  logic full;
  logic [SlotW-1:0] slot;
  logic enq_ok;
  logic cmp_take;

  always_comb begin
    load = '0;
    for (int i = 0; i < CarCapacity; i++) load = load + LoadW'(rv_q[i]);
  end
  assign full = (load == LoadW'(CarCapacity));
  assign slot = SlotW'((32'(head_q[call_q[FloorW-1:0]]) + 32'(cnt_q[call_q[FloorW-1:0]]))
                % QueueDepth);
  assign enq_ok = (32'(call_q) < FloorCount) && (32'(trip_q) < FloorCount) &&
                  (cnt_q[call_q[FloorW-1:0]] < CntW'(QueueDepth));

  // The compared floor takes the lead when it beats the best so far, or ties with
  // the top-floor preference set.
  assign cmp_take = cmd_i.cmp_step && ((prio_q[cmd_i.f] > best_p_q) ||
                    (prefer_top_i && prio_q[cmd_i.f] == best_p_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.enqueue && enq_ok) mem_q[{call_q[FloorW-1:0], slot}] <= trip_q[FloorW-1:0];
    if (cmd_i.board_rd) rd_q <= mem_q[{pos_q, head_q[pos_q]}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i; now_q <= now_i; call_q <= call_floor_i; trip_q <= trip_floor_i;
    end
    if (cmd_i.board_wr) begin
      rdest_q[cmd_i.k] <= rd_q;
      rtime_q[cmd_i.k] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; tgt_q <= '0; rv_q <= '0;
      best_q <= '0; best_p_q <= '0;
      boarded_q <= '0; alighted_q <= '0; status_q <= 1'b0;
      for (int i = 0; i < FloorCount; i++) begin
        head_q[i] <= '0; cnt_q[i] <= '0; stamp_q[i] <= '0; prio_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        boarded_q <= '0; alighted_q <= '0; status_q <= 1'b0;
      end
      if (cmd_i.clr_prio)
        for (int i = 0; i < FloorCount; i++) prio_q[i] <= '0;
      if (cmd_i.rider_acc && rv_q[cmd_i.k])
        prio_q[rdest_q[cmd_i.k]] <= prio_q[rdest_q[cmd_i.k]] +
                                    32'(16'(now_q - rtime_q[cmd_i.k]));
      if (cmd_i.floor_acc && !full && cnt_q[cmd_i.f] != '0)
        prio_q[cmd_i.f] <= prio_q[cmd_i.f] + 32'(16'(now_q - stamp_q[cmd_i.f]));
      if (cmd_i.cmp_init) begin
        best_q <= '0; best_p_q <= prio_q[0];
      end
      if (cmp_take) begin
        best_q <= cmd_i.f; best_p_q <= prio_q[cmd_i.f];
      end
      // The last compare lands in the same cycle as the target write.
      if (cmd_i.set_target) tgt_q <= cmp_take ? cmd_i.f : best_q;
      if (cmd_i.move) begin
        if (pos_q > tgt_q) pos_q <= pos_q - 1'b1;
        else if (pos_q < tgt_q) pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.enqueue) begin
        if (enq_ok) begin
          if (cnt_q[call_q[FloorW-1:0]] == '0) stamp_q[call_q[FloorW-1:0]] <= now_q;
          cnt_q[call_q[FloorW-1:0]] <= cnt_q[call_q[FloorW-1:0]] + 1'b1;
        end else begin
          status_q <= 1'b1;
        end
      end
      if (cmd_i.board_wr) begin
        rv_q[cmd_i.k] <= 1'b1;
        head_q[pos_q] <= SlotW'((32'(head_q[pos_q]) + 1) % QueueDepth);
        cnt_q[pos_q] <= cnt_q[pos_q] - 1'b1;
        stamp_q[pos_q] <= now_q;
        boarded_q <= boarded_q + 1'b1;
      end
      if (cmd_i.alight && rv_q[cmd_i.k] && rdest_q[cmd_i.k] == pos_q) begin
        rv_q[cmd_i.k] <= 1'b0;
        alighted_q <= alighted_q + 1'b1;
      end
    end
  end

  assign sts_o.func       = func_e'(func_q);
  assign sts_o.at_target  = (pos_q == tgt_q);
  assign sts_o.rider_free = !rv_q[cmd_i.k];
  assign sts_o.queue_busy = (cnt_q[pos_q] != '0);
  assign car_floor_o    = 4'(pos_q);
  assign target_floor_o = 4'(tgt_q);
  assign riders_o       = 4'(load);
  assign boarded_o      = boarded_q;
  assign alighted_o     = alighted_q;
  assign status_o       = status_q;
endmodule
`default_nettype wire

// ===== sv/eds_ctrl.sv =====
// Controller: sequences each item through the datapath and runs the handshakes.
`default_nettype none
module eds_ctrl import eds_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);
  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SDisp  = 8'b00000010,
    SRider = 8'b00000100,
    SFloor = 8'b00001000,
    SCmp   = 8'b00010000,
    SMove  = 8'b00100000,
    SBoard = 8'b01000000,
    SOut   = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [RiderW-1:0] k_q, k_d;
  logic [FloorW-1:0] f_q, f_d;
  logic rd_q, rd_d; // head read issued for rider k, or best search started

  always_comb begin
    state_d = state_q; k_d = k_q; f_d = f_q; rd_d = rd_q;
    cmd_o = '0;
    cmd_o.k = k_q; cmd_o.f = f_q;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.load = 1'b1; state_d = SDisp;
        end
      end
      SDisp: begin
        k_d = '0; f_d = '0; rd_d = 1'b0;
        case (sts_i.func)
          FuncTick: begin
            if (sts_i.at_target) begin
              cmd_o.clr_prio = 1'b1; state_d = SRider;
            end else state_d = SMove;
          end
          FuncEnqueue: begin
            cmd_o.enqueue = 1'b1; state_d = SOut;
          end
          FuncBoard: state_d = SBoard;
          default:   state_d = SRider;
        endcase
      end
      SRider: begin
        if (sts_i.func == FuncAlight) cmd_o.alight = 1'b1;
        else cmd_o.rider_acc = 1'b1;
        k_d = k_q + 1'b1;
        if (32'(k_q) == CarCapacity - 1)
          state_d = (sts_i.func == FuncAlight) ? SOut : SFloor;
      end
      SFloor: begin
        cmd_o.floor_acc = 1'b1;
        f_d = f_q + 1'b1;
        if (32'(f_q) == FloorCount - 1) begin
          f_d = FloorW'(1); state_d = SCmp;
        end
      end
      SCmp: begin
        if (f_q == FloorW'(1) && !rd_q) begin
          cmd_o.cmp_init = 1'b1; rd_d = 1'b1;
        end else begin
          cmd_o.cmp_step = 1'b1;
          f_d = f_q + 1'b1;
          if (32'(f_q) == FloorCount - 1) begin
            cmd_o.set_target = 1'b1; state_d = SMove;
          end
        end
      end
      SMove: begin
        cmd_o.move = 1'b1; state_d = SOut;
      end
      SBoard: begin
        if (!sts_i.queue_busy) state_d = SOut;
        else if (!sts_i.rider_free) begin
          k_d = k_q + 1'b1;
          if (32'(k_q) == CarCapacity - 1) state_d = SOut;
        end else if (!rd_q) begin
          cmd_o.board_rd = 1'b1; rd_d = 1'b1;
        end else begin
          cmd_o.board_wr = 1'b1; rd_d = 1'b0;
          k_d = k_q + 1'b1;
          if (32'(k_q) == CarCapacity - 1) state_d = SOut;
        end
      end
      SOut: begin
        out_valid = 1'b1;
        if (!out_stall) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; k_q <= '0; f_q <= '0; rd_q <= 1'b0;
    end else begin
      state_q <= state_d; k_q <= k_d; f_q <= f_d; rd_q <= rd_d;
    end
  end
endmodule
`default_nettype wire

// ===== sv/elevator_destination_scheduler_core.sv =====
// Top level of the elevator destination scheduler: controller plus datapath.
// An accepted item walks the sequencer to its output beat: an enqueue passes dispatch
// alone, a plain tick dispatch and a car move, alight every rider slot, board the
// rider slots with a head read per boarding, and a tick with a new target the rider
// slots, floors, best search and a car move. One item at a time; the next beat is taken the cycle
// after the result is taken, so the sequencer walking riders and floors sets the rate.
// Reset (rst_ni low, asynchronous) clears the car, rider valid bits, queue heads,
// counts and stamps; the queue store itself is not cleared and needs no sweep.
`default_nettype none
`include "assert_macros.svh"
module elevator_destination_scheduler_core import eds_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_prefer_top_i,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] func_i,
  input  wire logic [15:0] now_i,
  input  wire logic [3:0] call_floor_i,
  input  wire logic [3:0] trip_floor_i,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      car_floor_o,
  output logic [3:0]      target_floor_o,
  output logic [3:0]      riders_o,
  output logic [3:0]      boarded_o,
  output logic [3:0]      alighted_o,
  output logic            status_o
);
  // The tie-break register is always writable; the user must write it only while idle, the block does not enforce it.
  logic prefer_top_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prefer_top_q <= 1'b0;
    else if (cfg_valid && cfg_ready) prefer_top_q <= cfg_prefer_top_i;
  end

  eds_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd)
  );

  eds_datapath u_dp (
    .clk_i, .rst_ni, .prefer_top_i(prefer_top_q), .func_i, .now_i,
    .call_floor_i, .trip_floor_i, .cmd_i(cmd), .sts_o(sts),
    .car_floor_o, .target_floor_o, .riders_o, .boarded_o, .alighted_o, .status_o
  );

  // The car never holds more riders than its capacity.
  `ASSERT_CLK(a_riders, clk_i, rst_ni, riders_o <= 4'(CarCapacity), "rider overflow")
  // An input beat is never taken while a result beat is pending.
  `ASSERT_CLK(a_excl, clk_i, rst_ni, !(out_valid && !in_stall), "in and out overlap")
  // A result beat that is stalled keeps its car floor.
  `ASSERT_CLK(a_hold, clk_i, rst_ni, out_valid && out_stall |=> out_valid && $stable(car_floor_o), "result dropped")
endmodule
`default_nettype wire
